/* rtl/mtes_pkg.sv */
// Shared types and constants for the MIDI track event serializer.
// No dependencies; imported by every module of the block.
package mtes_pkg;

    // Command codes of an input word
    localparam logic [1:0] CMD_NOTE  = 2'd0;
    localparam logic [1:0] CMD_REST  = 2'd1;
    localparam logic [1:0] CMD_TEMPO = 2'd2;
    localparam logic [1:0] CMD_END   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_CHANNEL   = 1'b0;
    localparam logic CFG_REST_NOTE = 1'b1;

    localparam logic [6:0] REST_NOTE_RESET = 7'd36;

    // Fixed byte values of the track stream
    localparam logic [7:0] BYTE_ZERO       = 8'h00;
    localparam logic [7:0] BYTE_META       = 8'hFF;
    localparam logic [7:0] BYTE_SET_TEMPO  = 8'h51;
    localparam logic [7:0] BYTE_TEMPO_LEN  = 8'h03;
    localparam logic [7:0] BYTE_END_TRACK  = 8'h2F;
    localparam logic [3:0] NOTE_ON_NIBBLE  = 4'h9;
    localparam logic [3:0] NOTE_OFF_NIBBLE = 4'h8;

    localparam int DUR_W   = 28;
    localparam int GROUP_W = 7;

    // Sequencer to VLQ unit
    typedef struct packed {
        logic load;
        logic shift;
    } vlq_ctrl_t;

    // VLQ unit to sequencer
    typedef struct packed {
        logic [7:0] data;
        logic       final_group;
    } vlq_stat_t;

    // Sequencer to output register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } emit_t;

endpackage

/* rtl/mtes_vlq.sv */
// Variable-length quantity shifter: emits a 28-bit duration as 7-bit groups.
// Depends on mtes_pkg.
module mtes_vlq import mtes_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  vlq_ctrl_t          ctrl,
    input  logic [DUR_W-1:0]   duration,
    output vlq_stat_t          stat
);

    logic [DUR_W-1:0] shift_reg, shift_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [2:0]       load_cnt;
    logic [DUR_W-1:0] load_val;

    // Count the significant groups and left-align the first one.
    always_comb begin
        priority if (duration[27:21] != '0) begin
            load_cnt = 3'd4;
            load_val = duration;
        end else if (duration[20:14] != '0) begin
            load_cnt = 3'd3;
            load_val = {duration[20:0], 7'd0};
        end else if (duration[13:7] != '0) begin
            load_cnt = 3'd2;
            load_val = {duration[13:0], 14'd0};
        end else begin
            load_cnt = 3'd1;
            load_val = {duration[6:0], 21'd0};
        end
    end

    always_comb begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        if (ctrl.load) begin
            shift_next = load_val;
            cnt_next   = load_cnt;
        end else if (ctrl.shift) begin
            shift_next = {shift_reg[DUR_W-GROUP_W-1:0], {GROUP_W{1'b0}}};
            cnt_next   = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign stat.final_group = (cnt_reg == 3'd1);
    assign stat.data        = {cnt_reg != 3'd1, shift_reg[DUR_W-1 -: GROUP_W]};

    // A group is only taken while some remain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.shift && !ctrl.load |-> cnt_reg != 3'd0)
        else $error("VLQ shift with no groups left");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |=> cnt_reg != 3'd0 && cnt_reg <= 3'd4)
        else $error("VLQ group count out of range after load");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.shift && !ctrl.load && cnt_reg != 3'd1 |-> stat.data[7])
        else $error("continuation bit missing on a non-final group");

endmodule

/* rtl/mtes_seq.sv */
// Byte sequencer: walks one event through header, duration and tail bytes.
// Depends on mtes_pkg; drives the mtes_vlq unit.
module mtes_seq import mtes_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [1:0]  command,
    input  logic [6:0]  note_number,
    input  logic [6:0]  velocity,
    input  logic [23:0] tempo,
    input  logic [3:0]  channel,
    input  logic [6:0]  rest_note,
    input  logic        advance,
    input  vlq_stat_t   vlq_stat,
    output vlq_ctrl_t   vlq_ctrl,
    output emit_t       emit,
    output logic        busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HEAD = 2'd1;
    localparam logic [1:0] ST_VLQ  = 2'd2;
    localparam logic [1:0] ST_TAIL = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  cmd_reg;
    logic [6:0]  note_reg;
    logic [6:0]  velo_reg;
    logic [23:0] tempo_reg, tempo_next;
    logic        is_rest;
    logic [6:0]  ev_note;
    logic [7:0]  off_status;

    assign is_rest    = (cmd_reg == CMD_REST);
    assign ev_note    = is_rest ? rest_note : note_reg;
    assign off_status = {NOTE_OFF_NIBBLE, channel};

    always_comb begin
        emit.valid = (state_reg != ST_IDLE);
        emit.data  = BYTE_ZERO;
        emit.last  = 1'b0;
        unique case (state_reg)
            ST_HEAD: begin
                unique case (cnt_reg)
                    2'd0: emit.data = BYTE_ZERO;
                    2'd1: begin
                        if (cmd_reg == CMD_NOTE) begin
                            emit.data = {NOTE_ON_NIBBLE, channel};
                        end else if (is_rest) begin
                            emit.data = off_status;
                        end else begin
                            emit.data = BYTE_META;
                        end
                    end
                    2'd2: begin
                        unique case (cmd_reg)
                            CMD_NOTE, CMD_REST: emit.data = {1'b0, ev_note};
                            CMD_TEMPO:          emit.data = BYTE_SET_TEMPO;
                            default:            emit.data = BYTE_END_TRACK;
                        endcase
                    end
                    default: begin
                        unique case (cmd_reg)
                            CMD_NOTE:  emit.data = {1'b0, velo_reg};
                            CMD_TEMPO: emit.data = BYTE_TEMPO_LEN;
                            default:   emit.data = BYTE_ZERO;
                        endcase
                        emit.last = (cmd_reg == CMD_END);
                    end
                endcase
            end
            ST_VLQ: emit.data = vlq_stat.data;
            ST_TAIL: begin
                if (cmd_reg == CMD_TEMPO) begin
                    emit.data = tempo_reg[23:16];
                end else begin
                    unique case (cnt_reg)
                        2'd0:    emit.data = off_status;
                        2'd1:    emit.data = {1'b0, ev_note};
                        default: emit.data = BYTE_ZERO;
                    endcase
                end
                emit.last = (cnt_reg == 2'd2);
            end
            default: emit.data = BYTE_ZERO;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tempo_next = tempo_reg;
        if (start) begin
            state_next = ST_HEAD;
            cnt_next   = 2'd0;
            tempo_next = tempo;
        end else if (advance) begin
            unique case (state_reg)
                ST_HEAD: begin
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        cnt_next = 2'd0;
                        unique case (cmd_reg)
                            CMD_NOTE, CMD_REST: state_next = ST_VLQ;
                            CMD_TEMPO:          state_next = ST_TAIL;
                            default:            state_next = ST_IDLE;
                        endcase
                    end
                end
                ST_VLQ: begin
                    if (vlq_stat.final_group) begin
                        state_next = ST_TAIL;
                    end
                end
                ST_TAIL: begin
                    tempo_next = {tempo_reg[15:0], 8'd0};
                    cnt_next   = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2) begin
                        state_next = ST_IDLE;
                        cnt_next   = 2'd0;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        tempo_reg <= tempo_next;
        if (start) begin
            cmd_reg  <= command;
            note_reg <= note_number;
            velo_reg <= velocity;
        end
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign vlq_ctrl.load  = start;
    assign vlq_ctrl.shift = (state_reg == ST_VLQ) && advance;
    assign busy           = (state_reg != ST_IDLE);

endmodule

/* rtl/midi_track_event_serializer.sv */
// Top level of the MIDI track event serializer; holds the configuration
// registers and the output register. Depends on mtes_pkg, mtes_vlq, mtes_seq.
//
// Each accepted event word is turned into its Standard MIDI File track
// bytes, one byte per output word, with m_last high on the event's final
// byte. The block emits one byte per cycle while m_ready stays high, and no
// byte is emitted in the cycle that accepts the event. An event is 8 bytes
// for a note or rest plus one per extra 7-bit duration group, 7 bytes for
// tempo and 4 for end of track. The next event is accepted in the cycle after
// the final byte enters the output register, so that byte may still wait there.
// Duration bytes come from a 28-bit shift register that moves one 7-bit group
// per cycle while the output advances; tempo bytes from a 24-bit register
// that moves one byte per cycle while the output advances.
// Configuration writes take effect at once and must only be made while no
// event is open.
module midi_track_event_serializer import mtes_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [6:0]  s_note_number,
    input  logic [6:0]  s_velocity,
    input  logic [27:0] s_duration,
    input  logic [23:0] s_tempo,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);

    logic [3:0] channel_reg;
    logic [6:0] rest_note_reg;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_out_byte_reg;
    logic       m_last_reg;
    logic       busy;
    logic       start;
    logic       out_free;
    logic       out_load;
    emit_t      emit;
    vlq_ctrl_t  vlq_ctrl;
    vlq_stat_t  vlq_stat;

    assign s_ready  = !busy;
    assign start    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = emit.valid && out_free;

    mtes_vlq u_vlq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (vlq_ctrl),
        .duration (s_duration),
        .stat     (vlq_stat)
    );

    mtes_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .command     (s_command),
        .note_number (s_note_number),
        .velocity    (s_velocity),
        .tempo       (s_tempo),
        .channel     (channel_reg),
        .rest_note   (rest_note_reg),
        .advance     (out_free),
        .vlq_stat    (vlq_stat),
        .vlq_ctrl    (vlq_ctrl),
        .emit        (emit),
        .busy        (busy)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_out_byte_reg <= emit.data;
            m_last_reg     <= emit.last;
        end
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            channel_reg   <= 4'd0;
            rest_note_reg <= REST_NOTE_RESET;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en && cfg_index == CFG_CHANNEL) begin
                channel_reg <= cfg_data[3:0];
            end
            if (cfg_wr_en && cfg_index == CFG_REST_NOTE) begin
                rest_note_reg <= cfg_data;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_last     = m_last_reg;

    // An accepted event always produces at least one byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy && !s_ready)
        else $error("event accepted but sequencer not started");

    // Once the final byte is in the output register the sequencer is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && emit.last |=> s_ready)
        else $error("sequencer still busy after final byte");

    // The sequencer never offers a byte while idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid |-> !s_ready)
        else $error("byte offered while ready for a new event");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for midi_track_event_serializer: drives track events
// with bursty valid and a stalling receiver, predicts every output byte.
// Depends on rtl/mtes_pkg.sv and rtl/midi_track_event_serializer.sv.
`timescale 1ns / 100ps

module testbench import mtes_pkg::*; ();

    localparam int CYCLE_LIMIT = 500000;
    localparam int IDLE_CYCLES = 4;
    localparam int PHASE_EVENTS = 38;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } track_byte_t;

    // Predicts the track bytes of each accepted event and checks the stream.
    class track_byte_scoreboard;
        track_byte_t expected_bytes[$];
        logic [3:0]  channel;
        logic [6:0]  rest_note;
        int unsigned errors;

        function new();
            channel = 4'd0;
            rest_note = REST_NOTE_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic index, logic [6:0] value);
            if (index == CFG_CHANNEL) begin
                channel = value[3:0];
            end else begin
                rest_note = value;
            end
        endfunction

        function int pending_count();
            return expected_bytes.size();
        endfunction

        function void push_byte(logic [7:0] value, logic last);
            track_byte_t b;
            b.value = value;
            b.last = last;
            expected_bytes.push_back(b);
        endfunction

        // Delta time as 7-bit groups, most significant first, 0x80 on all but the final.
        function void push_delta(logic [27:0] ticks);
            logic [6:0]  groups[4];
            logic [27:0] v;
            int          count;
            v = ticks;
            count = 0;
            do begin
                groups[count] = v[6:0];
                count++;
                v = v >> GROUP_W;
            end while (v != 0 && count < 4);
            for (int i = count - 1; i >= 0; i--) begin
                push_byte({(i > 0), groups[i]}, 1'b0);
            end
        endfunction

        function void push_channel_event(logic [3:0] nibble, logic [6:0] note,
                                         logic [6:0] vel, logic last);
            push_byte({nibble, channel}, 1'b0);
            push_byte({1'b0, note}, 1'b0);
            push_byte({1'b0, vel}, last);
        endfunction

        function void note_event(logic [1:0] command, logic [6:0] note, logic [6:0] vel,
                                 logic [27:0] ticks, logic [23:0] tempo);
            push_byte(BYTE_ZERO, 1'b0);
            case (command)
                CMD_NOTE: begin
                    push_channel_event(NOTE_ON_NIBBLE, note, vel, 1'b0);
                    push_delta(ticks);
                    push_channel_event(NOTE_OFF_NIBBLE, note, 7'd0, 1'b1);
                end
                CMD_REST: begin
                    push_channel_event(NOTE_OFF_NIBBLE, rest_note, 7'd0, 1'b0);
                    push_delta(ticks);
                    push_channel_event(NOTE_OFF_NIBBLE, rest_note, 7'd0, 1'b1);
                end
                CMD_TEMPO: begin
                    push_byte(BYTE_META, 1'b0);
                    push_byte(BYTE_SET_TEMPO, 1'b0);
                    push_byte(BYTE_TEMPO_LEN, 1'b0);
                    push_byte(tempo[23:16], 1'b0);
                    push_byte(tempo[15:8], 1'b0);
                    push_byte(tempo[7:0], 1'b1);
                end
                default: begin
                    push_byte(BYTE_META, 1'b0);
                    push_byte(BYTE_END_TRACK, 1'b0);
                    push_byte(BYTE_ZERO, 1'b1);
                end
            endcase
        endfunction

        function void check_byte(logic [7:0] value, logic last);
            track_byte_t exp_byte;
            if (expected_bytes.size() == 0) begin
                $error("unexpected word: out_byte=%h last=%b", value, last);
                errors++;
                return;
            end
            exp_byte = expected_bytes.pop_front();
            if (value !== exp_byte.value) begin
                $error("out_byte mismatch: expected %h, actual %h", exp_byte.value, value);
                errors++;
            end
            if (last !== exp_byte.last) begin
                $error("last mismatch: expected %b, actual %b", exp_byte.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [6:0]  s_note_number;
    logic [6:0]  s_velocity;
    logic [27:0] s_duration;
    logic [23:0] s_tempo;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last;

    track_byte_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int          stall_left = 0;
    int          ready_mode = 0;
    int          mode_left = 0;
    int          burst_left = 1;

    midi_track_event_serializer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_note_number (s_note_number),
        .s_velocity    (s_velocity),
        .s_duration    (s_duration),
        .s_tempo       (s_tempo),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Receiver: the stall behavior switches at random between always ready, light
    // stalls and long ones.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_byte(m_out_byte, m_last);
        end
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 80);
        end else begin
            mode_left--;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (ready_mode == 1 && $urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else if (ready_mode == 2 && $urandom_range(0, 1) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Holds the word until the block takes it; valid stays high afterwards.
    task automatic send_event(input logic [1:0] command, input logic [6:0] note,
                              input logic [6:0] vel, input logic [27:0] ticks,
                              input logic [23:0] tempo);
        s_valid <= 1'b1;
        s_command <= command;
        s_note_number <= note;
        s_velocity <= vel;
        s_duration <= ticks;
        s_tempo <= tempo;
        do @(posedge aclk); while (!s_ready);
        sb.note_event(command, note, vel, ticks, tempo);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [3:0] channel, input logic [6:0] rest_note);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CHANNEL;
        cfg_data <= {3'b000, channel};
        @(posedge aclk);
        sb.write_reg(CFG_CHANNEL, {3'b000, channel});
        cfg_index <= CFG_REST_NOTE;
        cfg_data <= rest_note;
        @(posedge aclk);
        sb.write_reg(CFG_REST_NOTE, rest_note);
        cfg_wr_en <= 1'b0;
    endtask

    // Durations are spread evenly over one to four delta bytes.
    task automatic send_random_event();
        logic [1:0]  command;
        logic [31:0] mask;
        logic [27:0] ticks;
        int          pick;
        int          gap;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            command = CMD_NOTE;
        end else if (pick < 6) begin
            command = CMD_REST;
        end else if (pick < 8) begin
            command = CMD_TEMPO;
        end else begin
            command = CMD_END;
        end
        mask = (32'd1 << (GROUP_W * $urandom_range(1, 4))) - 32'd1;
        ticks = mask[27:0] & 28'($urandom);
        if ($urandom_range(0, 15) == 0) begin
            ticks = '0;
        end
        send_event(command, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   ticks, 24'($urandom));
        burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_CHANNEL;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_command <= CMD_NOTE;
        s_note_number <= '0;
        s_velocity <= '0;
        s_duration <= '0;
        s_tempo <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: field extremes and every delta length boundary.
        send_event(CMD_NOTE, 7'd0, 7'd0, 28'd0, 24'd0);
        send_event(CMD_NOTE, 7'd127, 7'd127, 28'd127, 24'd0);
        send_event(CMD_NOTE, 7'd60, 7'd100, 28'd128, 24'd0);
        send_event(CMD_NOTE, 7'd1, 7'd64, 28'd16383, 24'd0);
        send_event(CMD_NOTE, 7'd2, 7'd65, 28'd16384, 24'd0);
        send_event(CMD_NOTE, 7'd3, 7'd66, 28'd2097151, 24'd0);
        send_event(CMD_NOTE, 7'd4, 7'd67, 28'd2097152, 24'd0);
        send_event(CMD_NOTE, 7'd5, 7'd68, 28'hFFFFFFF, 24'hFFFFFF);
        // A rest ignores the note and velocity fields.
        send_event(CMD_REST, 7'd0, 7'd0, 28'd0, 24'd0);
        send_event(CMD_REST, 7'd127, 7'd127, 28'hFFFFFFF, 24'hFFFFFF);
        send_event(CMD_TEMPO, 7'd0, 7'd0, 28'd0, 24'd0);
        send_event(CMD_TEMPO, 7'd127, 7'd127, 28'hFFFFFFF, 24'hFFFFFF);
        send_event(CMD_TEMPO, 7'd42, 7'd17, 28'd999, 24'h07A120);
        send_event(CMD_END, 7'd0, 7'd0, 28'd0, 24'd0);
        send_event(CMD_END, 7'd127, 7'd127, 28'hFFFFFFF, 24'hFFFFFF);
        wait_idle();

        write_config(4'd15, 7'd0);
        send_event(CMD_NOTE, 7'd127, 7'd127, 28'd300, 24'd0);
        send_event(CMD_REST, 7'd10, 7'd20, 28'd129, 24'd0);
        wait_idle();
        write_config(4'd15, 7'd127);
        send_event(CMD_REST, 7'd0, 7'd0, 28'd0, 24'd0);
        send_event(CMD_NOTE, 7'd0, 7'd1, 28'd1, 24'd0);
        wait_idle();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: write_config(4'd0, 7'd127);
                2: write_config(4'd15, 7'd0);
                default: write_config(4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)));
            endcase
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                send_random_event();
            end
            wait_idle();
        end

        repeat (16) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
